[design/assert_macros.svh]
// Assertion macros shared by the RTL of the register block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("assertion failed");
// Expression must never be true at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

[design/nprb_pkg.sv]
// Package: address map, field widths and decode helpers of the register block.
`timescale 1ns / 1ps
`default_nettype none
package nprb_pkg;

  localparam int unsigned AddrW       = 6;
  localparam int unsigned NibW        = 4;
  localparam int unsigned ShadowDepth = 64;
  localparam int unsigned InDataW     = 16;
  localparam int unsigned OutDataW    = 80;

  // Register addresses
  localparam logic [5:0] ADDR_LCD_CTRL    = 6'h00;
  localparam logic [5:0] ADDR_CONTRAST_LO = 6'h01;
  localparam logic [5:0] ADDR_CONTRAST_HI = 6'h02;
  localparam logic [5:0] ADDR_SPARE_03    = 6'h03;
  localparam logic [5:0] ADDR_CRC_FIRST   = 6'h04;
  localparam logic [5:0] ADDR_CRC_LAST    = 6'h07;
  localparam logic [5:0] ADDR_ZERO_08     = 6'h08;
  localparam logic [5:0] ADDR_SPARE_09    = 6'h09;
  localparam logic [5:0] ADDR_UNKNOWN_0A  = 6'h0A;
  localparam logic [5:0] ADDR_ANN_LO      = 6'h0B;
  localparam logic [5:0] ADDR_ANN_HI      = 6'h0C;
  localparam logic [5:0] ADDR_SPARE_0E    = 6'h0E;
  localparam logic [5:0] ADDR_CARD_STATE  = 6'h0F;
  localparam logic [5:0] ADDR_SER_FIRST   = 6'h10;
  localparam logic [5:0] ADDR_SER_12      = 6'h12;
  localparam logic [5:0] ADDR_SER_14      = 6'h14;
  localparam logic [5:0] ADDR_SER_15      = 6'h15;
  localparam logic [5:0] ADDR_SER_16      = 6'h16;
  localparam logic [5:0] ADDR_SER_LAST    = 6'h17;
  localparam logic [5:0] ADDR_SPARE_FIRST = 6'h18;
  localparam logic [5:0] ADDR_SPARE_LAST  = 6'h1F;
  localparam logic [5:0] ADDR_BASE_FIRST  = 6'h20;
  localparam logic [5:0] ADDR_BASE_LAST   = 6'h24;
  localparam logic [5:0] ADDR_LOFS_FIRST  = 6'h25;
  localparam logic [5:0] ADDR_LOFS_LAST   = 6'h27;
  localparam logic [5:0] ADDR_LCNT_LO     = 6'h28;
  localparam logic [5:0] ADDR_LCNT_HI     = 6'h29;
  localparam logic [5:0] ADDR_UNK_FIRST   = 6'h2A;
  localparam logic [5:0] ADDR_UNK_LAST    = 6'h2D;
  localparam logic [5:0] ADDR_T1_CTRL     = 6'h2E;
  localparam logic [5:0] ADDR_T2_CTRL     = 6'h2F;
  localparam logic [5:0] ADDR_MENU_FIRST  = 6'h30;
  localparam logic [5:0] ADDR_MENU_LAST   = 6'h34;
  localparam logic [5:0] ADDR_UNK_35      = 6'h35;
  localparam logic [5:0] ADDR_UNK_36      = 6'h36;
  localparam logic [5:0] ADDR_T1_VALUE    = 6'h37;
  localparam logic [5:0] ADDR_T2_FIRST    = 6'h38;

  localparam logic [3:0] NIB_ALL_ONES = 4'hF;

  // Source of the read nibble
  typedef enum logic [3:0] {
    SRC_SHADOW,
    SRC_CRC,
    SRC_ZERO,
    SRC_CARD,
    SRC_SERIAL,
    SRC_T1_CTRL,
    SRC_T2_CTRL,
    SRC_T1_VALUE,
    SRC_T2_VALUE,
    SRC_UNKNOWN
  } rd_src_e;

  // Result payload
  typedef struct packed {
    logic [5:0]  line_count;
    logic [11:0] line_offset;
    logic [19:0] menu_addr;
    logic [19:0] base_addr;
    logic [7:0]  annunciators;
    logic [4:0]  contrast;
    logic [2:0]  hoffset;
    logic        enable;
    logic [3:0]  read_data;
    logic        serial_fwd;
    logic        unknown;
  } result_t;

  function automatic logic in_range(logic [5:0] a, logic [5:0] lo, logic [5:0] hi);
    return (a >= lo) && (a <= hi);
  endfunction

  function automatic rd_src_e decode_read(logic [5:0] a);
    rd_src_e src;
    if (in_range(a, ADDR_LCD_CTRL, ADDR_SPARE_03) || a == ADDR_SPARE_09 ||
        in_range(a, ADDR_ANN_LO, ADDR_SPARE_0E) ||
        in_range(a, ADDR_SPARE_FIRST, ADDR_SPARE_LAST) ||
        in_range(a, ADDR_LOFS_FIRST, ADDR_LCNT_HI)) begin
      src = SRC_SHADOW;
    end else if (in_range(a, ADDR_CRC_FIRST, ADDR_CRC_LAST)) begin
      src = SRC_CRC;
    end else if (a == ADDR_ZERO_08 || in_range(a, ADDR_MENU_FIRST, ADDR_MENU_LAST)) begin
      src = SRC_ZERO;
    end else if (a == ADDR_CARD_STATE) begin
      src = SRC_CARD;
    end else if (in_range(a, ADDR_SER_FIRST, ADDR_SER_12) || a == ADDR_SER_14 ||
                 a == ADDR_SER_15) begin
      src = SRC_SERIAL;
    end else if (a == ADDR_T1_CTRL) begin
      src = SRC_T1_CTRL;
    end else if (a == ADDR_T2_CTRL) begin
      src = SRC_T2_CTRL;
    end else if (a == ADDR_T1_VALUE) begin
      src = SRC_T1_VALUE;
    end else if (a >= ADDR_T2_FIRST) begin
      src = SRC_T2_VALUE;
    end else begin
      src = SRC_UNKNOWN;
    end
    return src;
  endfunction

  function automatic logic is_serial_write(logic [5:0] a);
    return in_range(a, ADDR_SER_FIRST, ADDR_SER_14) || a == ADDR_SER_16 ||
           a == ADDR_SER_LAST;
  endfunction

  function automatic logic is_unknown_write(logic [5:0] a);
    return a == ADDR_UNKNOWN_0A || in_range(a, ADDR_UNK_FIRST, ADDR_UNK_LAST) ||
           a == ADDR_UNK_35 || a == ADDR_UNK_36;
  endfunction

endpackage
`default_nettype wire

[design/nprb_ram.sv]
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
`default_nettype none
module nprb_ram #(
  parameter int unsigned Width = 4,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, holds while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

[design/nibble_peripheral_register_block.sv]
// Top level: nibble-wide peripheral register block with 64-address space.
// Usage:
//   Requests enter on the s_axis channel: tuser[0] = mode (1 write, 0 read),
//   tdata holds the address and write nibble. Each request yields exactly one
//   response on m_axis: tuser carries the unknown-address and serial-forward
//   flags, tdata the read nibble followed by all display register fields as
//   they stand after the request.
//   A request passes through the input register, where the shadow RAM is
//   also read, then through decode, register update and the response register.
//   Throughput is one request per cycle while m_axis_tready stays high; the
//   shadow RAM has one write and one read port, so a write followed by a read
//   of the same address is fine.
//   When m_axis_tready is low the response register holds, one more request
//   is absorbed by the input register, then s_axis_tready drops.
//   The card state nibble is written on the cfg channel (always ready); the user
//   must write it only while idle, the block itself does not enforce this.
//   Reset (rst_ni low) clears all architectural registers, the shadow valid
//   bits and the pipeline valids; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module nibble_peripheral_register_block (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // request channel
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // [5:0] address, [9:6] write_data, rest zero
  input  wire logic [0:0]  s_axis_tuser,   // [0] mode
  // response channel
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [3:0] read_data, [4] lcd_enable, [7:5] lcd_horizontal_offset,
  // [12:8] lcd_contrast_level, [20:13] lcd_annunciators, [40:21] lcd_base_address,
  // [60:41] lcd_menu_address, [72:61] lcd_line_offset_value, [78:73] lcd_line_count
  output logic [79:0]      m_axis_tdata,
  output logic [1:0]       m_axis_tuser,   // [0] unknown_address, [1] serial_forward
  // configuration write
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [3:0]  cfg_data_i
);
  import nprb_pkg::*;

  // Handshake
  logic in_acc;
  logic advance;
  logic s1_valid_q;
  logic out_valid_q;

  // Stage 1 request register
  logic       s1_mode_q;
  logic [5:0] s1_addr_q;
  logic [3:0] s1_data_q;
  logic       s1_shadow_vld_q;

  // Shadow store
  logic [ShadowDepth-1:0] shadow_vld_q;
  logic [3:0]             shadow_rdata;

  // Architectural registers
  logic [3:0]       card_state_q;
  logic [3:0][3:0]  crc_q, crc_d;
  logic [3:0]       t1_ctrl_q, t1_ctrl_d;
  logic [3:0]       t2_ctrl_q, t2_ctrl_d;
  logic [3:0]       t1_value_q, t1_value_d;
  logic [7:0][3:0]  t2_value_q, t2_value_d;
  logic [4:0][3:0]  base_q, base_d;
  logic [4:0][3:0]  menu_q, menu_d;
  logic [2:0][3:0]  lofs_q, lofs_d;
  logic [5:0]       lcnt_q, lcnt_d;
  logic [2:0]       hofs_q, hofs_d;
  logic             enable_q, enable_d;
  logic [4:0]       contrast_q, contrast_d;
  logic [7:0]       ann_q, ann_d;

  rd_src_e rd_src;
  result_t res_d, res_q;
  logic    wr_en;

  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign advance       = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || advance;
  assign cfg_ready_o   = 1'b1;
  assign wr_en         = advance && s1_mode_q;

  // Shadow RAM: written and read at request acceptance
  nprb_ram #(
    .Width (NibW),
    .Depth (ShadowDepth)
  ) u_shadow (
    .clk_i   (clk_i),
    .we_i    (in_acc && s_axis_tuser[0]),
    .waddr_i (s_axis_tdata[5:0]),
    .wdata_i (s_axis_tdata[9:6]),
    .re_i    (in_acc),
    .raddr_i (s_axis_tdata[5:0]),
    .rdata_o (shadow_rdata)
  );

  // Pipeline valids and shadow valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      shadow_vld_q <= '0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (in_acc && s_axis_tuser[0]) begin
        shadow_vld_q[s_axis_tdata[5:0]] <= 1'b1;
      end
    end
  end

  // Stage 1 payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_mode_q       <= s_axis_tuser[0];
      s1_addr_q       <= s_axis_tdata[5:0];
      s1_data_q       <= s_axis_tdata[9:6];
      s1_shadow_vld_q <= shadow_vld_q[s_axis_tdata[5:0]];
    end
  end

  // Register write merge
  always_comb begin
    crc_d      = crc_q;
    t1_ctrl_d  = t1_ctrl_q;
    t2_ctrl_d  = t2_ctrl_q;
    t1_value_d = t1_value_q;
    t2_value_d = t2_value_q;
    base_d     = base_q;
    menu_d     = menu_q;
    lofs_d     = lofs_q;
    lcnt_d     = lcnt_q;
    hofs_d     = hofs_q;
    enable_d   = enable_q;
    contrast_d = contrast_q;
    ann_d      = ann_q;
    if (wr_en) begin
      if (s1_addr_q == ADDR_LCD_CTRL) begin
        hofs_d   = s1_data_q[2:0];
        enable_d = s1_data_q[3];
      end else if (s1_addr_q == ADDR_CONTRAST_LO) begin
        contrast_d[3:0] = s1_data_q;
      end else if (s1_addr_q == ADDR_CONTRAST_HI) begin
        contrast_d[4] = s1_data_q[0];
      end else if (in_range(s1_addr_q, ADDR_CRC_FIRST, ADDR_CRC_LAST)) begin
        crc_d[s1_addr_q[1:0]] = s1_data_q;
      end else if (s1_addr_q == ADDR_ANN_LO) begin
        ann_d[3:0] = s1_data_q;
      end else if (s1_addr_q == ADDR_ANN_HI) begin
        ann_d[7:4] = s1_data_q;
      end else if (in_range(s1_addr_q, ADDR_BASE_FIRST, ADDR_BASE_LAST)) begin
        base_d[s1_addr_q[2:0]] = s1_data_q;
      end else if (in_range(s1_addr_q, ADDR_LOFS_FIRST, ADDR_LOFS_LAST)) begin
        lofs_d[2'(s1_addr_q - ADDR_LOFS_FIRST)] = s1_data_q;
      end else if (s1_addr_q == ADDR_LCNT_LO) begin
        lcnt_d[3:0] = s1_data_q;
      end else if (s1_addr_q == ADDR_LCNT_HI) begin
        lcnt_d[5:4] = s1_data_q[1:0];
      end else if (s1_addr_q == ADDR_T1_CTRL) begin
        t1_ctrl_d = s1_data_q;
      end else if (s1_addr_q == ADDR_T2_CTRL) begin
        t2_ctrl_d = s1_data_q;
      end else if (in_range(s1_addr_q, ADDR_MENU_FIRST, ADDR_MENU_LAST)) begin
        menu_d[s1_addr_q[2:0]] = s1_data_q;
      end else if (s1_addr_q == ADDR_T1_VALUE) begin
        t1_value_d = s1_data_q;
      end else if (s1_addr_q >= ADDR_T2_FIRST) begin
        t2_value_d[s1_addr_q[2:0]] = s1_data_q;
      end
    end
  end

  // Read decode and response build
  always_comb begin
    rd_src            = decode_read(s1_addr_q);
    res_d             = '0;
    res_d.enable      = enable_d;
    res_d.hoffset     = hofs_d;
    res_d.contrast    = contrast_d;
    res_d.annunciators = ann_d;
    res_d.base_addr   = base_d;
    res_d.menu_addr   = menu_d;
    res_d.line_offset = lofs_d;
    res_d.line_count  = lcnt_d;
    if (s1_mode_q) begin
      res_d.unknown    = is_unknown_write(s1_addr_q);
      res_d.serial_fwd = is_serial_write(s1_addr_q);
    end else begin
      case (rd_src)
        SRC_SHADOW:   res_d.read_data = s1_shadow_vld_q ? shadow_rdata : '0;
        SRC_CRC:      res_d.read_data = crc_q[s1_addr_q[1:0]];
        SRC_ZERO:     res_d.read_data = '0;
        SRC_CARD:     res_d.read_data = card_state_q;
        SRC_SERIAL:   res_d.serial_fwd = 1'b1;
        SRC_T1_CTRL:  res_d.read_data = t1_ctrl_q;
        SRC_T2_CTRL:  res_d.read_data = t2_ctrl_q;
        SRC_T1_VALUE: res_d.read_data = t1_value_q;
        SRC_T2_VALUE: res_d.read_data = t2_value_q[s1_addr_q[2:0]];
        default: begin
          res_d.read_data = NIB_ALL_ONES;
          res_d.unknown   = 1'b1;
        end
      endcase
    end
  end

  // Architectural state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      card_state_q  <= '0;
      crc_q         <= '0;
      t1_ctrl_q     <= '0;
      t2_ctrl_q     <= '0;
      t1_value_q    <= '0;
      t2_value_q    <= '0;
      base_q        <= '0;
      menu_q        <= '0;
      lofs_q        <= '0;
      lcnt_q        <= '0;
      hofs_q        <= '0;
      enable_q      <= 1'b0;
      contrast_q    <= '0;
      ann_q         <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        card_state_q <= cfg_data_i;
      end
      crc_q      <= crc_d;
      t1_ctrl_q  <= t1_ctrl_d;
      t2_ctrl_q  <= t2_ctrl_d;
      t1_value_q <= t1_value_d;
      t2_value_q <= t2_value_d;
      base_q     <= base_d;
      menu_q     <= menu_d;
      lofs_q     <= lofs_d;
      lcnt_q     <= lcnt_d;
      hofs_q     <= hofs_d;
      enable_q   <= enable_d;
      contrast_q <= contrast_d;
      ann_q      <= ann_d;
    end
  end

  // Response register
  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = {res_q.serial_fwd, res_q.unknown};
  assign m_axis_tdata  = {1'b0, res_q.line_count, res_q.line_offset, res_q.menu_addr,
                          res_q.base_addr, res_q.annunciators, res_q.contrast,
                          res_q.hoffset, res_q.enable, res_q.read_data};

  // Checks
  `ASSERT_CLK(a_s1_holds, clk_i, rst_ni, (s1_valid_q && !advance) |=> s1_valid_q)
  `ASSERT_CLK(a_stall_cause, clk_i, rst_ni, !s_axis_tready |-> (out_valid_q && !m_axis_tready))
  `ASSERT_CLK(a_write_reads_zero, clk_i, rst_ni, (advance && s1_mode_q) |=> (m_axis_tdata[3:0] == 4'h0))
  `ASSERT_NEVER(a_flags_exclusive, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser[0] && m_axis_tuser[1])

endmodule
`default_nettype wire

[sim/nibble_peripheral_register_block_test.sv]
// Testbench: random and directed bus accesses checked against a behavioral register-block model.
`timescale 1ns / 1ps
module nibble_peripheral_register_block_test;
  import nprb_pkg::*;

  // Access kinds on tuser[0]
  localparam logic MODE_READ  = 1'b0;
  localparam logic MODE_WRITE = 1'b1;

  // Addresses the package leaves unnamed
  localparam logic [5:0] ADDR_SER_13   = 6'h13;
  localparam logic [5:0] ADDR_T2_LAST  = 6'h3F;

  localparam int unsigned HOLDOFF_CYCLES = 300;

  // One directed request; rd/unk/ser are checked as typed when fixed is set
  typedef struct packed {
    logic       mode;
    logic [5:0] addr;
    logic [3:0] data;
    logic       fixed;
    logic [3:0] rd;
    logic       unk;
    logic       ser;
  } access_vec_t;

  // Everything one response carries
  typedef struct packed {
    logic [3:0]  rd;
    logic        unk;
    logic        ser;
    logic        en;
    logic [2:0]  hofs;
    logic [4:0]  contrast;
    logic [7:0]  ann;
    logic [19:0] base;
    logic [19:0] menu;
    logic [11:0] lofs;
    logic [5:0]  lcnt;
  } panel_resp_t;

  localparam access_vec_t DIRECTED [25] = '{
    '{MODE_READ,  ADDR_LCD_CTRL,    4'h0, 1'b1, 4'h0, 1'b0, 1'b0},
    '{MODE_READ,  ADDR_ZERO_08,     4'hF, 1'b1, 4'h0, 1'b0, 1'b0},
    '{MODE_READ,  ADDR_UNKNOWN_0A,  4'h0, 1'b1, 4'hF, 1'b1, 1'b0},
    '{MODE_READ,  ADDR_CARD_STATE,  4'h0, 1'b1, 4'h0, 1'b0, 1'b0},
    '{MODE_READ,  ADDR_SER_FIRST,   4'h0, 1'b1, 4'h0, 1'b0, 1'b1},
    '{MODE_READ,  ADDR_SER_13,      4'h0, 1'b1, 4'hF, 1'b1, 1'b0},
    '{MODE_READ,  ADDR_BASE_FIRST,  4'h0, 1'b1, 4'hF, 1'b1, 1'b0},
    '{MODE_READ,  ADDR_MENU_FIRST,  4'h0, 1'b1, 4'h0, 1'b0, 1'b0},
    '{MODE_READ,  ADDR_T2_LAST,     4'h0, 1'b1, 4'h0, 1'b0, 1'b0},
    '{MODE_WRITE, ADDR_LCD_CTRL,    4'hF, 1'b1, 4'h0, 1'b0, 1'b0},
    '{MODE_WRITE, ADDR_CONTRAST_LO, 4'hF, 1'b1, 4'h0, 1'b0, 1'b0},
    '{MODE_WRITE, ADDR_CONTRAST_HI, 4'hF, 1'b1, 4'h0, 1'b0, 1'b0},
    '{MODE_WRITE, ADDR_ANN_HI,      4'hF, 1'b1, 4'h0, 1'b0, 1'b0},
    '{MODE_WRITE, ADDR_BASE_LAST,   4'hF, 1'b1, 4'h0, 1'b0, 1'b0},
    '{MODE_WRITE, ADDR_MENU_LAST,   4'hF, 1'b1, 4'h0, 1'b0, 1'b0},
    '{MODE_WRITE, ADDR_LCNT_HI,     4'hF, 1'b1, 4'h0, 1'b0, 1'b0},
    '{MODE_WRITE, ADDR_LOFS_LAST,   4'hF, 1'b1, 4'h0, 1'b0, 1'b0},
    '{MODE_WRITE, ADDR_UNKNOWN_0A,  4'h5, 1'b1, 4'h0, 1'b1, 1'b0},
    '{MODE_WRITE, ADDR_SER_16,      4'hA, 1'b1, 4'h0, 1'b0, 1'b1},
    '{MODE_WRITE, ADDR_UNK_36,      4'h0, 1'b1, 4'h0, 1'b1, 1'b0},
    '{MODE_WRITE, ADDR_T2_LAST,     4'hF, 1'b1, 4'h0, 1'b0, 1'b0},
    '{MODE_READ,  ADDR_T2_LAST,     4'h0, 1'b1, 4'hF, 1'b0, 1'b0},
    '{MODE_WRITE, ADDR_CRC_LAST,    4'hC, 1'b1, 4'h0, 1'b0, 1'b0},
    '{MODE_READ,  ADDR_CRC_LAST,    4'h0, 1'b1, 4'hC, 1'b0, 1'b0},
    '{MODE_WRITE, ADDR_LCD_CTRL,    4'h0, 1'b1, 4'h0, 1'b0, 1'b0}
  };

  // DUT connections
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;   // [5:0] address, [9:6] write_data
  logic [0:0]  s_axis_tuser = '0;   // [0] mode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b1;
  logic [79:0] m_axis_tdata;        // [3:0] read_data, [4] enable, [7:5] hoffset, [12:8] contrast,
                                    // [20:13] annunciators, [40:21] base, [60:41] menu,
                                    // [72:61] line offset, [78:73] line count
  logic [1:0]  m_axis_tuser;        // [0] unknown_address, [1] serial_forward
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [3:0]  cfg_data_i = '0;

  // Mirror of the register block
  logic [3:0]  shadow_mirror [64];
  logic [15:0] crc_mirror;
  logic [3:0]  t1_ctrl_mirror, t2_ctrl_mirror, t1_value_mirror;
  logic [31:0] t2_value_mirror;
  logic [3:0]  card_mirror;
  logic        disp_en;
  logic [2:0]  disp_hofs;
  logic [4:0]  disp_contrast;
  logic [7:0]  disp_ann;
  logic [19:0] disp_base, disp_menu;
  logic [11:0] disp_lofs;
  logic [5:0]  disp_lcnt;

  panel_resp_t expected_panel_q [$];

  int unsigned error_count = 0;
  int unsigned read_count = 0, write_count = 0, unk_count = 0, ser_count = 0;
  int unsigned responses_seen = 0;
  int unsigned burst_left = 0;
  int unsigned holdoff_left = 0, holdoffs_done = 0;
  int unsigned style_left = 0, stall_pct = 0;

  nibble_peripheral_register_block DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  function automatic logic addr_in(logic [5:0] a, logic [5:0] lo, logic [5:0] hi);
    return (a >= lo) && (a <= hi);
  endfunction

  function automatic int nib_shift(logic [5:0] a, logic [5:0] first);
    return 4 * (int'(a) - int'(first));
  endfunction

  // Apply one access to the mirror and return the response it should produce
  function automatic panel_resp_t predict_access(logic m, logic [5:0] a, logic [3:0] d);
    panel_resp_t r;
    r = '0;
    if (m == MODE_WRITE) begin
      if (a == ADDR_LCD_CTRL) begin
        disp_hofs = d[2:0];
        disp_en   = d[3];
      end else if (a == ADDR_CONTRAST_LO) begin
        disp_contrast[3:0] = d;
      end else if (a == ADDR_CONTRAST_HI) begin
        disp_contrast[4] = d[0];
      end else if (addr_in(a, ADDR_CRC_FIRST, ADDR_CRC_LAST)) begin
        crc_mirror[nib_shift(a, ADDR_CRC_FIRST) +: 4] = d;
      end else if (a == ADDR_ANN_LO) begin
        disp_ann[3:0] = d;
      end else if (a == ADDR_ANN_HI) begin
        disp_ann[7:4] = d;
      end else if (addr_in(a, ADDR_BASE_FIRST, ADDR_BASE_LAST)) begin
        disp_base[nib_shift(a, ADDR_BASE_FIRST) +: 4] = d;
      end else if (addr_in(a, ADDR_LOFS_FIRST, ADDR_LOFS_LAST)) begin
        disp_lofs[nib_shift(a, ADDR_LOFS_FIRST) +: 4] = d;
      end else if (a == ADDR_LCNT_LO) begin
        disp_lcnt[3:0] = d;
      end else if (a == ADDR_LCNT_HI) begin
        disp_lcnt[5:4] = d[1:0];
      end else if (a == ADDR_T1_CTRL) begin
        t1_ctrl_mirror = d;
      end else if (a == ADDR_T2_CTRL) begin
        t2_ctrl_mirror = d;
      end else if (addr_in(a, ADDR_MENU_FIRST, ADDR_MENU_LAST)) begin
        disp_menu[nib_shift(a, ADDR_MENU_FIRST) +: 4] = d;
      end else if (a == ADDR_T1_VALUE) begin
        t1_value_mirror = d;
      end else if (a >= ADDR_T2_FIRST) begin
        t2_value_mirror[nib_shift(a, ADDR_T2_FIRST) +: 4] = d;
      end else if (a == ADDR_UNKNOWN_0A || addr_in(a, ADDR_UNK_FIRST, ADDR_UNK_LAST) ||
                   a == ADDR_UNK_35 || a == ADDR_UNK_36) begin
        r.unk = 1'b1;
      end
      r.ser = addr_in(a, ADDR_SER_FIRST, ADDR_SER_14) || a == ADDR_SER_16 ||
              a == ADDR_SER_LAST;
      shadow_mirror[a] = d;
    end else begin
      if (addr_in(a, ADDR_LCD_CTRL, ADDR_SPARE_03) || a == ADDR_SPARE_09 ||
          addr_in(a, ADDR_ANN_LO, ADDR_SPARE_0E) ||
          addr_in(a, ADDR_SPARE_FIRST, ADDR_SPARE_LAST) ||
          addr_in(a, ADDR_LOFS_FIRST, ADDR_LCNT_HI)) begin
        r.rd = shadow_mirror[a];
      end else if (addr_in(a, ADDR_CRC_FIRST, ADDR_CRC_LAST)) begin
        r.rd = crc_mirror[nib_shift(a, ADDR_CRC_FIRST) +: 4];
      end else if (a == ADDR_ZERO_08 || addr_in(a, ADDR_MENU_FIRST, ADDR_MENU_LAST)) begin
        r.rd = '0;
      end else if (a == ADDR_CARD_STATE) begin
        r.rd = card_mirror;
      end else if (addr_in(a, ADDR_SER_FIRST, ADDR_SER_12) || a == ADDR_SER_14 ||
                   a == ADDR_SER_15) begin
        r.ser = 1'b1;
      end else if (a == ADDR_T1_CTRL) begin
        r.rd = t1_ctrl_mirror;
      end else if (a == ADDR_T2_CTRL) begin
        r.rd = t2_ctrl_mirror;
      end else if (a == ADDR_T1_VALUE) begin
        r.rd = t1_value_mirror;
      end else if (a >= ADDR_T2_FIRST) begin
        r.rd = t2_value_mirror[nib_shift(a, ADDR_T2_FIRST) +: 4];
      end else begin
        r.rd  = NIB_ALL_ONES;
        r.unk = 1'b1;
      end
    end
    // display fields show their state after the access
    r.en       = disp_en;
    r.hofs     = disp_hofs;
    r.contrast = disp_contrast;
    r.ann      = disp_ann;
    r.base     = disp_base;
    r.menu     = disp_menu;
    r.lofs     = disp_lofs;
    r.lcnt     = disp_lcnt;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [19:0] got, logic [19:0] want);
    error_count++;
    $display("[%0t] MISMATCH %s: got %0h, expected %0h", $time, what, got, want);
  endtask

  task automatic check_field(string what, logic [19:0] got, logic [19:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // Compare one accepted response with the oldest expectation
  task automatic check_response();
    panel_resp_t want;
    responses_seen++;
    if (expected_panel_q.size() == 0) begin
      report_mismatch("response with nothing pending", m_axis_tdata[19:0], '0);
    end else begin
      want = expected_panel_q.pop_front();
      check_field("read_data", m_axis_tdata[3:0], want.rd);
      check_field("unknown_address", m_axis_tuser[0], want.unk);
      check_field("serial_forward", m_axis_tuser[1], want.ser);
      check_field("lcd_enable", m_axis_tdata[4], want.en);
      check_field("lcd_horizontal_offset", m_axis_tdata[7:5], want.hofs);
      check_field("lcd_contrast_level", m_axis_tdata[12:8], want.contrast);
      check_field("lcd_annunciators", m_axis_tdata[20:13], want.ann);
      check_field("lcd_base_address", m_axis_tdata[40:21], want.base);
      check_field("lcd_menu_address", m_axis_tdata[60:41], want.menu);
      check_field("lcd_line_offset_value", m_axis_tdata[72:61], want.lofs);
      check_field("lcd_line_count", m_axis_tdata[78:73], want.lcnt);
    end
  endtask

  // Offer one request, hold it until taken, then record what should come back
  task automatic issue_access(logic m, logic [5:0] a, logic [3:0] d,
                              logic fixed = 1'b0, logic [3:0] rd = '0,
                              logic unk = 1'b0, logic ser = 1'b0);
    panel_resp_t want;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, d, a};
    s_axis_tuser  <= m;
    do @(posedge clk_i); while (!s_axis_tready);
    want = predict_access(m, a, d);
    if (fixed) begin
      want.rd  = rd;
      want.unk = unk;
      want.ser = ser;
    end
    expected_panel_q.push_back(want);
    if (m == MODE_WRITE) write_count++; else read_count++;
    if (want.unk) unk_count++;
    if (want.ser) ser_count++;
  endtask

  // Bursts of requests with random gaps; long bursts give idle-free stretches
  task automatic pace_sender();
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
    end
  endtask

  // Stop offering and let every pending response come back
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (expected_panel_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_card_state(logic [3:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    card_mirror = v;
  endtask

  // Random traffic: single accesses half the time, the rest write/read-back sequences
  task automatic run_random_phase(int unsigned count);
    int unsigned n;
    int unsigned len;
    logic [5:0]  a;
    n = 0;
    while (n < count) begin
      a = 6'($urandom_range(0, 63));
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          issue_access(1'($urandom), a, 4'($urandom));
          pace_sender();
          n++;
        end
        5, 6, 7: begin
          issue_access(MODE_WRITE, a, 4'($urandom));
          pace_sender();
          issue_access(MODE_READ, a, 4'($urandom));
          pace_sender();
          n += 2;
        end
        default: begin
          // fill a multi-nibble span, then read it back
          len = $urandom_range(2, 8);
          for (int unsigned i = 0; i < len; i++) begin
            issue_access(MODE_WRITE, a + 6'(i), 4'($urandom));
            pace_sender();
          end
          for (int unsigned i = 0; i < len; i++) begin
            issue_access(MODE_READ, a + 6'(i), 4'($urandom));
            pace_sender();
          end
          n += 2 * len;
        end
      endcase
    end
  endtask

  // Response side: check, then pick tready by style, with two long hold-offs
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) check_response();
    if (holdoff_left != 0) begin
      holdoff_left--;
      m_axis_tready <= 1'b0;
    end else if ((holdoffs_done == 0 && responses_seen >= 100) ||
                 (holdoffs_done == 1 && responses_seen >= 420)) begin
      holdoffs_done++;
      holdoff_left = HOLDOFF_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      if (style_left == 0) begin
        case ($urandom_range(0, 3))
          0:       stall_pct = 0;
          1:       stall_pct = 20;
          2:       stall_pct = 50;
          default: stall_pct = 85;
        endcase
        style_left = $urandom_range(16, 96);
      end else begin
        style_left--;
      end
      m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("nibble_peripheral_register_block_test: done, errors");
    $finish;
  end

  // Stimulus
  initial begin
    logic [3:0] card_setting;
    foreach (shadow_mirror[i]) shadow_mirror[i] = '0;
    crc_mirror      = '0;
    t1_ctrl_mirror  = '0;
    t2_ctrl_mirror  = '0;
    t1_value_mirror = '0;
    t2_value_mirror = '0;
    card_mirror     = '0;
    disp_en         = 1'b0;
    disp_hofs       = '0;
    disp_contrast   = '0;
    disp_ann        = '0;
    disp_base       = '0;
    disp_menu       = '0;
    disp_lofs       = '0;
    disp_lcnt       = '0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset values, field extremes and the odd addresses
    foreach (DIRECTED[k]) begin
      issue_access(DIRECTED[k].mode, DIRECTED[k].addr, DIRECTED[k].data,
                   DIRECTED[k].fixed, DIRECTED[k].rd, DIRECTED[k].unk, DIRECTED[k].ser);
      pace_sender();
    end
    wait_drained();

    // random phases, card state changed only while idle
    for (int p = 0; p < 4; p++) begin
      card_setting = (p == 0) ? 4'hF : (p == 1) ? 4'h0 : 4'($urandom_range(1, 14));
      write_card_state(card_setting);
      issue_access(MODE_READ, ADDR_CARD_STATE, 4'h0);
      pace_sender();
      run_random_phase(155);
      wait_drained();
    end

    $display("Covered %0d reads and %0d writes, %0d unknown-address and %0d serial responses,",
             read_count, write_count, unk_count, ser_count);
    $display("four card state settings and %0d long response hold-offs.", holdoffs_done);
    if (error_count == 0) begin
      $display("nibble_peripheral_register_block_test: done, clean");
    end else begin
      $display("nibble_peripheral_register_block_test: done, errors");
    end
    $finish;
  end

endmodule
